// ----- rtl/kmdr_pkg.sv -----
package kmdr_pkg;

  localparam int unsigned MaxChars  = 4;
  localparam int unsigned SlotCount = 4;
  localparam int unsigned CntW      = 3;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DELAY    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL = 2'd2;

  localparam logic [CfgDataW-1:0] DebounceRst = 16'd50;
  localparam logic [CfgDataW-1:0] DelayRst    = 16'd500;
  localparam logic [CfgDataW-1:0] IntervalRst = 16'd120;

  localparam logic [7:0] ChBacktick = 8'h60;

  typedef enum logic [3:0] {
    K_NONE    = 4'd0,
    K_UP      = 4'd1,
    K_DOWN    = 4'd2,
    K_LEFT    = 4'd3,
    K_RIGHT   = 4'd4,
    K_SELECT  = 4'd5,
    K_BACK    = 4'd6,
    K_RESCAN  = 4'd7,
    K_CONNECT = 4'd8,
    K_SAVE    = 4'd9,
    K_CHAR    = 4'd10
  } key_e;

  // One classified scan: clr marks an idle scan that clears the hold state.
  typedef struct packed {
    logic [31:0] now;
    logic        clr;
    key_e        code;
    logic [7:0]  ch;
  } qent_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] cnt;
  } qstat_t;

  function automatic key_e nav_map(input logic [7:0] c);
    key_e k;
    unique case (c) inside
      8'h2C:               k = K_LEFT;    // ,
      8'h2F:               k = K_RIGHT;   // /
      8'h3B, 8'h75, 8'h55: k = K_UP;      // ; u U
      8'h2E, 8'h64, 8'h44: k = K_DOWN;    // . d D
      8'h60, 8'h62, 8'h42: k = K_BACK;    // ` b B
      8'h65, 8'h45:        k = K_SELECT;  // e E
      8'h72, 8'h52:        k = K_RESCAN;  // r R
      8'h63, 8'h43:        k = K_CONNECT; // c C
      8'h73, 8'h53:        k = K_SAVE;    // s S
      default:             k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/kmdr_scan_if.sv -----
interface kmdr_scan_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        key_pressed;
  logic        state_changed;
  logic        enter_flag;
  logic        delete_flag;
  logic        password_mode;
  logic [2:0]  char_count;
  logic [7:0]  char_slot0;
  logic [7:0]  char_slot1;
  logic [7:0]  char_slot2;
  logic [7:0]  char_slot3;

  modport source (
    output valid, now_ms, key_pressed, state_changed, enter_flag, delete_flag,
           password_mode, char_count, char_slot0, char_slot1, char_slot2, char_slot3,
    input  ready
  );
  modport sink (
    input  valid, now_ms, key_pressed, state_changed, enter_flag, delete_flag,
           password_mode, char_count, char_slot0, char_slot1, char_slot2, char_slot3,
    output ready
  );
endinterface

// ----- rtl/kmdr_event_if.sv -----
interface kmdr_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  key_code;
  logic [7:0]  char_out;
  logic [31:0] event_time;

  modport source (output valid, key_code, char_out, event_time, input ready);
  modport sink (input valid, key_code, char_out, event_time, output ready);
endinterface

// ----- rtl/kmdr_front.sv -----
module kmdr_front
  import kmdr_pkg::*;
(
  kmdr_scan_if.sink scan,
  output logic      push_o,
  output qent_t     ent_o,
  input  qstat_t    stat_i
);

  logic [7:0]      slots [SlotCount];
  logic [CntW-1:0] cnt_lim;

  assign slots[0] = scan.char_slot0;
  assign slots[1] = scan.char_slot1;
  assign slots[2] = scan.char_slot2;
  assign slots[3] = scan.char_slot3;

  assign cnt_lim = (scan.char_count > CntW'(MaxChars)) ? CntW'(MaxChars) : scan.char_count;

  always_comb begin
    key_e       code;
    logic [7:0] ch;
    logic       done;
    key_e       m;
    code = K_NONE;
    ch   = 8'd0;
    done = 1'b0;
    m    = K_NONE;
    if (scan.enter_flag) begin
      code = K_SELECT;
    end else if (scan.delete_flag) begin
      code = K_BACK;
    end else begin
      // first slot decides in raw mode, first mapped slot in navigation mode
      for (int i = 0; i < SlotCount; i++) begin
        m = nav_map(slots[i]);
        if (!done && (CntW'(i) < cnt_lim)) begin
          if (scan.password_mode) begin
            if (slots[i] == ChBacktick) begin
              code = K_BACK;
            end else begin
              code = K_CHAR;
              ch   = slots[i];
            end
            done = 1'b1;
          end else if (m != K_NONE) begin
            code = m;
            done = 1'b1;
          end
        end
      end
    end
    if (!scan.key_pressed) begin
      code = K_NONE;
      ch   = 8'd0;
    end
    ent_o.now  = scan.now_ms;
    ent_o.clr  = !scan.key_pressed && !scan.state_changed;
    ent_o.code = code;
    ent_o.ch   = ch;
  end

  assign scan.ready = !stat_i.full;
  assign push_o     = scan.valid && !stat_i.full;

endmodule

// ----- rtl/kmdr_fifo.sv -----
module kmdr_fifo
  import kmdr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  qent_t  ent_i,
  input  logic   pop_i,
  output qent_t  ent_o,
  output qstat_t stat_o
);

  qent_t            mem [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= ent_i;
    end
  end

  assign ent_o        = mem[rd_q];
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.cnt   = cnt_q;

endmodule

// ----- rtl/kmdr_back.sv -----
module kmdr_back
  import kmdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  qent_t               ent_i,
  input  qstat_t              stat_i,
  output logic                pop_o,
  kmdr_event_if.source        ev
);

  logic [CfgDataW-1:0] debounce_q, delay_q, interval_q;
  logic [31:0]         last_emit_q, last_emit_d;
  key_e                last_key_q, last_key_d;
  logic [31:0]         hold_q, hold_d;
  logic                ov_q, ov_d;
  key_e                code_q;
  logic [7:0]          ch_q;
  logic [31:0]         time_q;

  logic        take, same, arrow, emit;
  logic [31:0] hs_eff, since_emit, since_hold;

  assign take  = !stat_i.empty && (!ov_q || ev.ready);
  assign pop_o = take;

  assign hs_eff     = (hold_q == '0) ? ent_i.now : hold_q;
  assign since_emit = ent_i.now - last_emit_q;
  assign since_hold = ent_i.now - hs_eff;
  assign same       = (ent_i.code == last_key_q);
  assign arrow      = (ent_i.code == K_UP) || (ent_i.code == K_DOWN) ||
                      (ent_i.code == K_LEFT) || (ent_i.code == K_RIGHT);

  always_comb begin
    if (ent_i.clr || (ent_i.code == K_NONE)) begin
      emit = 1'b0;
    end else if (same) begin
      emit = arrow && (since_hold >= {16'd0, delay_q}) &&
             (since_emit >= {16'd0, interval_q});
    end else begin
      emit = (since_emit >= {16'd0, debounce_q});
    end
  end

  always_comb begin
    last_emit_d = last_emit_q;
    last_key_d  = last_key_q;
    hold_d      = hold_q;
    if (take) begin
      if (ent_i.clr) begin
        last_key_d = K_NONE;
        hold_d     = '0;
      end else if (ent_i.code != K_NONE) begin
        if (same) begin
          hold_d = hs_eff;
        end else if (emit) begin
          hold_d = ent_i.now;
        end
        if (emit) begin
          last_key_d  = ent_i.code;
          last_emit_d = ent_i.now;
        end
      end
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (take) begin
      ov_d = 1'b1;
    end else if (ev.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceRst;
      delay_q     <= DelayRst;
      interval_q  <= IntervalRst;
      last_emit_q <= '0;
      last_key_q  <= K_NONE;
      hold_q      <= '0;
      ov_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEBOUNCE: debounce_q <= cfg_wdata_i;
          CFG_DELAY:    delay_q    <= cfg_wdata_i;
          CFG_INTERVAL: interval_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      last_emit_q <= last_emit_d;
      last_key_q  <= last_key_d;
      hold_q      <= hold_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      code_q <= emit ? ent_i.code : K_NONE;
      ch_q   <= emit ? ent_i.ch : 8'd0;
      time_q <= ent_i.now;
    end
  end

  assign ev.valid      = ov_q;
  assign ev.key_code   = code_q;
  assign ev.char_out   = ch_q;
  assign ev.event_time = time_q;

endmodule

// ----- rtl/key_map_debounce_repeat_top.sv -----
// Keyboard scan decoder with debounce and typematic repeat. Every accepted scan item
// yields exactly one event item on the output channel, in order: a navigation code,
// select/back, a literal character (password mode) or none. Sustained rate is one item
// per clock in both directions while the receiver holds ready. An accepted scan is
// written into the classify queue, then resolved into the output register when the
// back end takes it from the queue, and its event item is valid from there. The
// input side keeps accepting while the output is stalled until the four-entry queue
// fills (one more item waits in the output register). The hold and debounce state is
// updated by the back end in the same cycle an item leaves the queue, so back-to-back
// scans see each other's effect without bubbles. Write configuration only when the
// block is idle; register indexes beyond the list are ignored.
module key_map_debounce_repeat_top
  import kmdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  kmdr_scan_if.sink           scan_i,
  kmdr_event_if.source        event_o
);

  logic   push, pop;
  qent_t  ent_in, ent_out;
  qstat_t qstat;

  // Front: map flags and character slots to a key code, no state involved.
  kmdr_front u_front (
    .scan   (scan_i),
    .push_o (push),
    .ent_o  (ent_in),
    .stat_i (qstat)
  );

  // Queue: decouple classification from the stateful back end.
  kmdr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ent_i  (ent_in),
    .pop_i  (pop),
    .ent_o  (ent_out),
    .stat_o (qstat)
  );

  // Back: apply debounce, hold and repeat timing, then register the event item.
  kmdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ent_i       (ent_out),
    .stat_i      (qstat),
    .pop_o       (pop),
    .ev          (event_o)
  );

  // Queue occupancy never passes its depth.
  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.cnt <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  // An accepted scan is in the queue at the next edge.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_i.valid && scan_i.ready) |=> !qstat.empty)
    else $error("accepted scan item missing from queue");

  // Only a character event carries a character.
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && (event_o.key_code != K_CHAR)) |-> (event_o.char_out == 8'd0))
    else $error("char_out set on a non-character event");

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import kmdr_pkg::*;

  // Abort the run if it is still going after this many clocks.
  localparam int unsigned CycleLimit = 300000;
  // Register index past the end of the list; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  // Random scans per configuration phase.
  localparam int unsigned ScansPerPhase = 240;
  // Receiver hold-off used to back the block up into its input.
  localparam int unsigned ParkCycles = 80;

  // One keyboard scan as driven onto the input channel.
  typedef struct packed {
    logic [31:0]     now;
    logic            pressed;
    logic            changed;
    logic            enter;
    logic            del;
    logic            raw;
    logic [2:0]      cnt;
    logic [3:0][7:0] slot;
  } scan_t;

  // One decoded key item as expected on the output channel.
  typedef struct packed {
    key_e        code;
    logic [7:0]  ch;
    logic [31:0] stamp;
  } key_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  kmdr_scan_if scan_ch ();
  kmdr_event_if key_ch ();

  key_map_debounce_repeat_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .scan_i      (scan_ch),
    .event_o     (key_ch)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the configuration and the hold/debounce
  // bookkeeping, advanced once per accepted scan.
  // ---------------------------------------------------------------------------
  logic [15:0] dbnc_ms     = DebounceRst;
  logic [15:0] delay_ms    = DelayRst;
  logic [15:0] interval_ms = IntervalRst;
  logic [31:0] emit_ms     = '0;
  key_e        held_key    = K_NONE;
  logic [31:0] hold_ms     = '0;   // zero means no hold start recorded

  scan_t      queued_scans[$];
  key_event_t predicted_events[$];

  scan_t       cur_scan = '0;
  bit          scan_done = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  bit          park_req = 1'b0;
  int          park_left = 0;
  logic [31:0] rx_cycle = '0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned scans_queued = 0;
  logic [31:0] phase_ms = '0;

  // Navigation characters; the first eight are the arrow keys.
  logic [7:0] nav_chars [19] = '{8'h2C, 8'h2F, 8'h3B, 8'h75, 8'h55, 8'h2E, 8'h64,
                                 8'h44, 8'h60, 8'h62, 8'h42, 8'h65, 8'h45, 8'h72,
                                 8'h52, 8'h63, 8'h43, 8'h73, 8'h53};

  // Configuration sets for the random phases: all-zero, all-max, tight, mixed.
  logic [15:0] cfg_sets [4][3] = '{'{16'd0, 16'd0, 16'd0},
                                   '{16'hFFFF, 16'hFFFF, 16'hFFFF},
                                   '{16'd10, 16'd40, 16'd15},
                                   '{16'd1, 16'hFFFF, 16'd0}};

  function automatic key_e nav_code_of(input logic [7:0] c);
    case (c)
      8'h2C:               return K_LEFT;     // comma
      8'h2F:               return K_RIGHT;    // slash
      8'h3B, 8'h75, 8'h55: return K_UP;       // semicolon, u, U
      8'h2E, 8'h64, 8'h44: return K_DOWN;     // period, d, D
      8'h60, 8'h62, 8'h42: return K_BACK;     // backtick, b, B
      8'h65, 8'h45:        return K_SELECT;
      8'h72, 8'h52:        return K_RESCAN;
      8'h63, 8'h43:        return K_CONNECT;
      8'h73, 8'h53:        return K_SAVE;
      default:             return K_NONE;
    endcase
  endfunction

  // Decode one scan into the key item it should produce, updating hold state.
  function automatic key_event_t decode_scan(input scan_t s);
    key_event_t  ev;
    key_e        k;
    logic [7:0]  ch;
    int unsigned n;
    int unsigned i;
    logic        found;
    logic [31:0] since_hold;
    logic [31:0] since_emit;
    ev.code  = K_NONE;
    ev.ch    = 8'h00;
    ev.stamp = s.now;
    k        = K_NONE;
    ch       = 8'h00;
    found    = 1'b0;
    n        = 32'(s.cnt);
    if (n > MaxChars) n = MaxChars;
    if (n > SlotCount) n = SlotCount;

    if (!s.pressed) begin
      // Idle scan drops the hold; a release scan leaves everything alone.
      if (!s.changed) begin
        held_key = K_NONE;
        hold_ms  = '0;
      end
      return ev;
    end

    if (s.enter) begin
      k = K_SELECT;
    end else if (s.del) begin
      k = K_BACK;
    end else begin
      for (i = 0; i < n && !found; i++) begin
        if (s.raw) begin
          // Password mode decides on the first slot alone.
          if (s.slot[i] == ChBacktick) begin
            k = K_BACK;
          end else begin
            k  = K_CHAR;
            ch = s.slot[i];
          end
          found = 1'b1;
        end else begin
          k     = nav_code_of(s.slot[i]);
          found = (k != K_NONE);
        end
      end
    end

    if (k == K_NONE) return ev;

    if (k == held_key) begin
      if (hold_ms == '0) hold_ms = s.now;
      since_hold = s.now - hold_ms;
      since_emit = s.now - emit_ms;
      // Only arrows repeat; everything else fires once per hold.
      if (!(k >= K_UP && k <= K_RIGHT)) return ev;
      if (since_hold < {16'h0, delay_ms}) return ev;
      if (since_emit < {16'h0, interval_ms}) return ev;
    end else begin
      since_emit = s.now - emit_ms;
      if (since_emit < {16'h0, dbnc_ms}) return ev;
      hold_ms = s.now;
    end

    held_key = k;
    emit_ms  = s.now;
    ev.code  = k;
    ev.ch    = (k == K_CHAR) ? ch : 8'h00;
    return ev;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic enqueue(input scan_t s);
    queued_scans.push_back(s);
    scans_queued++;
  endtask

  task automatic push_scan(input logic [31:0] now, input int pressed, input int changed,
                           input int enter, input int del, input int raw,
                           input int cnt, input logic [7:0] c0,
                           input logic [7:0] c1 = 8'h00, input logic [7:0] c2 = 8'h00,
                           input logic [7:0] c3 = 8'h00);
    scan_t s;
    s.now     = now;
    s.pressed = 1'(pressed);
    s.changed = 1'(changed);
    s.enter   = 1'(enter);
    s.del     = 1'(del);
    s.raw     = 1'(raw);
    s.cnt     = 3'(cnt);
    s.slot    = {c3, c2, c1, c0};
    enqueue(s);
  endtask

  function automatic scan_t random_scan();
    logic [71:0] r;
    r = {$urandom(), $urandom(), 8'($urandom_range(0, 255))};
    return scan_t'(r);
  endfunction

  // One press-hold-release session with random timing, or a noise scan.
  task automatic add_session(input int unsigned step_max);
    scan_t s;
    int    kind;
    int    hold_n;
    int    j;
    int    p;
    s    = random_scan();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      enqueue(s);
      return;
    end
    s.enter = (kind <= 1);
    s.del   = (kind == 2) || (kind <= 1 && $urandom_range(0, 1) == 1);
    s.raw   = (kind >= 7) || (kind <= 2 && $urandom_range(0, 1) == 1);
    if (kind >= 3 && kind <= 6) begin
      s.cnt = 3'($urandom_range(1, 4));
      p     = $urandom_range(0, s.cnt - 1);
      // Favor the arrows so the repeat path gets exercised.
      s.slot[p] = ($urandom_range(0, 1) == 1) ? nav_chars[$urandom_range(0, 7)]
                                              : nav_chars[$urandom_range(0, 18)];
    end else if (kind >= 7) begin
      s.cnt = 3'($urandom_range(1, 4));
      if ($urandom_range(0, 5) == 0) s.slot[0] = ChBacktick;
    end
    hold_n = $urandom_range(1, 12);
    for (j = 0; j < hold_n; j++) begin
      phase_ms  += $urandom_range(0, step_max);
      s.now     = phase_ms;
      s.pressed = 1'b1;
      s.changed = (j == 0) || ($urandom_range(0, 3) == 0);
      // Roll to another character mid-hold in password mode.
      if (s.raw && j > 0 && $urandom_range(0, 4) == 0) s.slot[0] = 8'($urandom_range(0, 255));
      enqueue(s);
    end
    if ($urandom_range(0, 4) != 0) begin
      phase_ms  += $urandom_range(0, step_max);
      s.now     = phase_ms;
      s.pressed = 1'b0;
      s.changed = 1'b1;
      enqueue(s);
      for (j = $urandom_range(0, 2); j > 0; j--) begin
        phase_ms  += $urandom_range(0, step_max);
        s.now     = phase_ms;
        s.changed = 1'b0;
        enqueue(s);
      end
    end
  endtask

  // Wait until every queued scan is in and every predicted item is out.
  task automatic settle();
    while (queued_scans.size() != 0 || scan_ch.valid || predicted_events.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    // Mirror the write; the block is idle, so nothing in flight sees the change.
    if (idx == CFG_DEBOUNCE) dbnc_ms = data;
    else if (idx == CFG_DELAY) delay_ms = data;
    else if (idx == CFG_INTERVAL) interval_ms = data;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed scans under the reset configuration, then random
  // sessions over several register settings.
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    int unsigned target;
    int unsigned step_max;
    logic [15:0] d;
    logic [15:0] r;
    logic [15:0] iv;
    logic [15:0] top;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset config: debounce 50, delay 500, interval 120.
    push_scan(0, 0, 0, 0, 0, 0, 0, 0);                      // idle scan
    push_scan(0, 1, 1, 1, 0, 0, 0, 0);                      // enter inside debounce: drop
    push_scan(100, 1, 0, 1, 0, 0, 0, 0);                    // select
    push_scan(200, 1, 0, 1, 0, 0, 0, 0);                    // held select: once per hold
    push_scan(210, 0, 1, 0, 0, 0, 0, 0);                    // release scan keeps state
    push_scan(300, 1, 1, 0, 1, 0, 0, 0);                    // delete: back
    push_scan(400, 1, 1, 0, 0, 0, 1, ",");                  // left
    push_scan(450, 1, 0, 0, 0, 0, 1, ",");                  // held, before delay
    push_scan(950, 1, 0, 0, 0, 0, 1, ",");                  // first repeat
    push_scan(1000, 1, 0, 0, 0, 0, 1, ",");                 // inside interval
    push_scan(1070, 1, 0, 0, 0, 0, 1, ",");                 // second repeat
    push_scan(2000, 1, 1, 0, 0, 0, 4, "x", "z", "q", "/");  // first mapped slot wins
    push_scan(2100, 1, 1, 0, 0, 0, 7, "x", "x", "x", "x");  // oversized count, no map
    push_scan(3000, 1, 1, 0, 0, 1, 3, "a", "b", "c");       // literal char
    push_scan(3100, 1, 1, 0, 0, 1, 1, "Z");                 // other char, same code: drop
    push_scan(3200, 1, 1, 0, 0, 1, 1, ChBacktick);          // backtick in password: back
    push_scan(3210, 1, 1, 0, 0, 1, 0, 8'hFF);               // password, nothing in slots
    push_scan(32'hFFFF_FFF0, 1, 1, 0, 0, 0, 1, "u");        // up just before wrap
    push_scan(32'h0000_0200, 1, 0, 0, 0, 0, 1, "u");        // repeat across the wrap
    push_scan(32'hFFFF_FFFF, 0, 0, 1, 1, 1, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // idle
    push_scan(0, 1, 1, 0, 0, 0, 2, 8'hFF, "S");             // save at time zero
    push_scan(20, 1, 0, 0, 0, 0, 2, 8'hFF, "S");            // hold start was unset
    push_scan(100, 1, 1, 0, 0, 0, 4, 8'hFF, 8'hFF, 8'hFF, "e");
    push_scan(120, 1, 1, 0, 0, 0, 1, "r");                  // rescan inside debounce
    push_scan(200, 1, 1, 0, 0, 0, 1, "R");                  // rescan
    push_scan(320, 1, 1, 0, 0, 0, 1, "b");                  // back

    phase_ms = $urandom();
    for (ph = 0; ph <= 5; ph++) begin
      if (ph > 0) begin
        settle();
        if (ph <= 4) begin
          d  = cfg_sets[ph-1][0];
          r  = cfg_sets[ph-1][1];
          iv = cfg_sets[ph-1][2];
        end else begin
          d  = 16'($urandom_range(0, 300));
          r  = 16'($urandom_range(0, 300));
          iv = 16'($urandom_range(0, 300));
        end
        write_reg(CFG_DEBOUNCE, d);
        write_reg(CFG_DELAY, r);
        write_reg(CFG_INTERVAL, iv);
        if (ph == 3) write_reg(CfgUnused, 16'($urandom_range(0, 65535)));
        // Run the all-max phase across the 32-bit wrap.
        phase_ms = (ph == 2) ? 32'hFFFF_0000 : $urandom();
      end
      top = dbnc_ms;
      if (delay_ms > top) top = delay_ms;
      if (interval_ms > top) top = interval_ms;
      step_max = (top >> 2) + 30;
      target   = scans_queued + ScansPerPhase;
      while (scans_queued < target) add_session(step_max);
      // Back the block up while the sender keeps offering items.
      if (ph == 1 || ph == 3) begin
        @(posedge clk_i);
        park_req = 1'b1;
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: present queued scans in bursts with random gaps. Hold an item
  // until it is taken; advance only after a handshake.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic nv;
    nv = rst_ni && scan_ch.valid && !scan_done;
    if (rst_ni && !nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (queued_scans.size() != 0) begin
        cur_scan  = queued_scans.pop_front();
        scan_done = 1'b0;
        nv        = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // Now and then a long burst with no idle cycles at all.
          burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    scan_ch.valid         <= nv;
    scan_ch.now_ms        <= cur_scan.now;
    scan_ch.key_pressed   <= cur_scan.pressed;
    scan_ch.state_changed <= cur_scan.changed;
    scan_ch.enter_flag    <= cur_scan.enter;
    scan_ch.delete_flag   <= cur_scan.del;
    scan_ch.password_mode <= cur_scan.raw;
    scan_ch.char_count    <= cur_scan.cnt;
    scan_ch.char_slot0    <= cur_scan.slot[0];
    scan_ch.char_slot1    <= cur_scan.slot[1];
    scan_ch.char_slot2    <= cur_scan.slot[2];
    scan_ch.char_slot3    <= cur_scan.slot[3];
  end

  // Predict at the edge where the scan is taken, so the order matches the block.
  always @(posedge clk_i) begin
    if (rst_ni && scan_ch.valid && scan_ch.ready && !scan_done) begin
      predicted_events.push_back(decode_scan(cur_scan));
      scan_done = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern selected by bits 8 to 6 of rx_cycle; on request,
  // drop ready for a long stretch so the input side fills up and stalls.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic rdy;
    rx_cycle++;
    if (park_req) begin
      park_left = ParkCycles;
      park_req  = 1'b0;
    end
    if (park_left > 0) begin
      park_left--;
      rdy = 1'b0;
    end else begin
      case (rx_cycle[8:6])
        3'd0, 3'd1, 3'd6: rdy = 1'b1;
        3'd2:             rdy = 1'($urandom_range(0, 1));
        3'd3:             rdy = ($urandom_range(0, 3) == 0);
        3'd4:             rdy = (rx_cycle[1:0] != 2'b11);
        3'd5:             rdy = rx_cycle[2];
        default:          rdy = ($urandom_range(0, 9) != 0);
      endcase
    end
    key_ch.ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted key item with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni && key_ch.valid && key_ch.ready) begin
      if (predicted_events.size() == 0) begin
        report("key item with nothing predicted, key_code", 32'(key_ch.key_code), 32'd0);
      end else begin
        want = predicted_events.pop_front();
        if (key_ch.key_code !== want.code)
          report("key_code", 32'(key_ch.key_code), 32'(want.code));
        if (key_ch.char_out !== want.ch)
          report("char_out", 32'(key_ch.char_out), 32'(want.ch));
        if (key_ch.event_time !== want.stamp)
          report("event_time", key_ch.event_time, want.stamp);
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
